@@ sv/lgu_pkg.sv @@
// Package for the loss and gradient unit: payload structs, constants, commands.
// No dependencies.
`default_nettype none
package lgu_pkg;
  localparam int unsigned MAX_BATCH_DEFAULT = 1048576;
  localparam logic signed [31:0] LN_TINY_Q16 = -32'sd1358120;
  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] prediction;
    logic signed [31:0] label;
    logic               last;
  } lgu_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] average;
    logic               average_valid;
    logic               last_out;
  } lgu_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start work
    logic ln_init;   // normalise mantissa
    logic ln_step;   // one squaring
    logic ln_mul;    // ln2 scale
    logic ce_mul;    // y * L
    logic fin;       // produce value
    logic fold;      // add last value to batch sum and count
    logic div_init;
    logic div_step;
    logic emit;      // load output register
  } lgu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_ln;
    logic ln_done;
    logic is_avg;
    logic div_done;
  } lgu_sts_t;
endpackage
`default_nettype wire

@@ sv/lgu_datapath.sv @@
// Value path: request register, iterative ln, cross-entropy multiply, MSE and derivative.
// Depends on lgu_pkg.
`default_nettype none
module lgu_datapath import lgu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         loss_kind,
  input  wire lgu_in_t      req,
  input  wire lgu_cmd_t     cmd,
  output logic signed [31:0] val,
  output logic              mode,
  output logic              last,
  output logic              need_ln,
  output logic              ln_done,
  output logic              is_avg
);
  lgu_in_t            req_r;
  logic        [31:0] m_r;               // Q1.30 mantissa, top bit spare
  logic        [31:0] m_nxt;
  logic        [4:0]  i_r;
  logic        [29:0] frac_r;
  logic        [4:0]  k_r;
  logic signed [31:0] l_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] val_r;

  // top set bit
  logic [4:0] k_c;
  always_comb begin
    k_c = '0;
    for (int b = 0; b < 32; b++) if (req_r.prediction[b]) k_c = 5'(b);
  end

  logic [63:0] sq;
  assign sq = 64'(m_r) * 64'(m_r);
  assign m_nxt = 32'(sq >> 30);

  logic signed [36:0] l2;
  logic        [36:0] l2mag;
  logic        [67:0] lnp;
  logic        [31:0] lnq;
  assign l2 = (37'(k_r) - 37'sd16) * 37'sd1073741824 + 37'(frac_r);
  assign l2mag = l2[36] ? 37'(-l2) : 37'(l2);
  assign lnp = 68'(l2mag) * 68'(LN2_Q30) + (68'd1 << 43);
  assign lnq = 32'(lnp >> 44);

  logic signed [32:0] d;
  logic        [32:0] dmag;
  logic        [65:0] dsq;
  assign d = 33'(req_r.prediction) - 33'(req_r.label);
  assign dmag = d[32] ? 33'(-d) : 33'(d);
  assign dsq = 66'(dmag) * 66'(dmag);

  function automatic logic signed [31:0] sat(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

  // -(y*L), truncated toward zero after the Q16 shift
  logic signed [63:0] cep;
  logic        [63:0] cemag;
  logic signed [65:0] cetr;
  logic signed [31:0] value_c;
  assign cep = -prod_r;
  assign cemag = cep[63] ? 64'(-cep) : 64'(cep);
  assign cetr = cep[63] ? -66'(cemag >> 16) : 66'(cemag >> 16);
  always_comb begin
    if (req_r.mode) begin
      value_c = loss_kind ? ONE_Q16 : sat(66'(d) <<< 1);
    end else if (!loss_kind) begin
      value_c = (dsq[65:16] > 50'd2147483647) ? 32'sh7fffffff : 32'(dsq[47:16]);
    end else if (req_r.label <= 0) begin
      value_c = '0;
    end else begin
      value_c = sat(cetr);
    end
  end

  assign need_ln = !req_r.mode && loss_kind && (req_r.label > 0)
                   && (req_r.prediction > 0);
  assign ln_done = (i_r == 5'd0);
  assign is_avg  = !req_r.mode && req_r.last;
  assign val     = val_r;
  assign mode    = req_r.mode;
  assign last    = req_r.last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
      l_r   <= LN_TINY_Q16;
    end
    if (cmd.ln_init) begin
      m_r    <= 32'(64'(req_r.prediction) << (5'd30 - k_c));
      k_r    <= k_c;
      frac_r <= '0;
      i_r    <= 5'd30;
    end
    if (cmd.ln_step) begin
      i_r <= i_r - 5'd1;
      if (m_nxt[31]) begin
        m_r <= m_nxt >> 1;
        frac_r[i_r - 5'd1] <= 1'b1;
      end else begin
        m_r <= m_nxt;
      end
    end
    if (cmd.ln_mul) l_r <= l2[36] ? -lnq : lnq;
    if (cmd.ce_mul) prod_r <= 64'(req_r.label) * 64'(l_r);
    if (cmd.fin) val_r <= value_c;
  end
endmodule
`default_nettype wire

@@ sv/lgu_ctrl.sv @@
// Controller FSM: sequences ln iteration, multiply, accumulate, divide, output.
// Depends on lgu_pkg.
`default_nettype none
module lgu_ctrl import lgu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire lgu_sts_t sts,
  output lgu_cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_LNI = 10'b0000000010, S_LNS = 10'b0000000100,
    S_LNM  = 10'b0000001000, S_CEM = 10'b0000010000, S_FIN = 10'b0000100000,
    S_ACC  = 10'b0001000000, S_DVI = 10'b0010000000, S_DIV = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } st_t;
  st_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic out_free;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    unique case (st_r)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; st_nxt = S_LNI; end
      S_LNI: begin
        if (sts.need_ln) begin cmd.ln_init = 1'b1; st_nxt = S_LNS; end
        else st_nxt = S_CEM;
      end
      S_LNS: begin cmd.ln_step = 1'b1; if (sts.ln_done) begin
        cmd.ln_step = 1'b0; st_nxt = S_LNM; end end
      S_LNM: begin cmd.ln_mul = 1'b1; st_nxt = S_CEM; end
      S_CEM: begin cmd.ce_mul = 1'b1; st_nxt = S_FIN; end
      S_FIN: begin cmd.fin = 1'b1; st_nxt = sts.is_avg ? S_ACC : S_EMIT; end
      S_ACC: begin cmd.fold = 1'b1; st_nxt = S_DVI; end
      S_DVI: begin cmd.div_init = 1'b1; st_nxt = S_DIV; end
      S_DIV: begin
        if (!sts.div_done) cmd.div_step = 1'b1;
        else st_nxt = S_EMIT;
      end
      S_EMIT: if (out_free) begin cmd.emit = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sv/lgu_acc.sv @@
// Batch accumulator: saturating sum and count, 64-bit serial divide, output register.
// Depends on lgu_pkg.
`default_nettype none
module lgu_acc import lgu_pkg::*; #(
  parameter int unsigned MAX_BATCH = MAX_BATCH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lgu_cmd_t           cmd,
  input  wire logic signed [31:0] val,
  input  wire logic               mode,
  input  wire logic               last,
  input  wire logic               is_avg,
  output logic                    div_done,
  output lgu_out_t                res
);
  localparam logic [20:0] CAP = (MAX_BATCH > 2097151) ? 21'd2097151 : 21'(MAX_BATCH);

  logic signed [63:0] sum_r, sum_nxt;
  logic        [20:0] cnt_r, cnt_nxt;
  logic        [63:0] dq_r, drem_r;     // quotient / remainder magnitudes
  logic        [20:0] dvs_r;
  logic        [6:0]  dbit_r;
  logic               dneg_r;
  lgu_out_t           res_r;

  function automatic logic signed [31:0] sat(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return 32'(x);
  endfunction

  logic signed [64:0] s65;
  assign s65 = 65'(sum_r) + 65'(val);
  always_comb begin
    if (!s65[64] && s65[63]) sum_nxt = 64'sh7fffffffffffffff;
    else if (s65[64] && !s65[63]) sum_nxt = 64'sh8000000000000000;
    else sum_nxt = 64'(s65);
    cnt_nxt = (cnt_r < CAP) ? cnt_r + 21'd1 : cnt_r;
  end

  logic [64:0] dtrial;
  assign dtrial = {drem_r, dq_r[63]} - 65'(dvs_r);

  assign div_done = (dbit_r == 7'd0);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      dbit_r <= '0;
    end else begin
      if (cmd.fold) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
      if (cmd.div_init) begin
        dneg_r <= sum_r[63];
        dq_r   <= sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
        drem_r <= '0;
        dvs_r  <= (cnt_r == '0) ? 21'd1 : cnt_r;
        dbit_r <= 7'd64;
      end
      if (cmd.div_step && dbit_r != 7'd0) begin
        dbit_r <= dbit_r - 7'd1;
        if (!dtrial[64]) begin
          drem_r <= dtrial[63:0];
          dq_r   <= {dq_r[62:0], 1'b1};
        end else begin
          drem_r <= {drem_r[62:0], dq_r[63]};
          dq_r   <= {dq_r[62:0], 1'b0};
        end
      end
      if (cmd.emit) begin
        res_r.value         <= val;
        res_r.last_out      <= last;
        res_r.average_valid <= is_avg;
        if (is_avg) begin
          res_r.average <= sat(dneg_r ? -66'(dq_r) : 66'(dq_r));
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          res_r.average <= '0;
          if (!mode) begin
            sum_r <= sum_nxt;
            cnt_r <= cnt_nxt;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/lgu_dp_fold.sv @@
// Datapath: joins the value path and the batch accumulator, gathers status.
// Depends on lgu_pkg, lgu_datapath, lgu_acc.
`default_nettype none
module lgu_dp_fold import lgu_pkg::*; #(
  parameter int unsigned MAX_BATCH = MAX_BATCH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     loss_kind,
  input  wire lgu_in_t  req,
  input  wire lgu_cmd_t cmd,
  output lgu_sts_t      sts,
  output lgu_out_t      res
);
  logic signed [31:0] val;
  logic               mode;
  logic               last;
  logic               need_ln;
  logic               ln_done;
  logic               is_avg;
  logic               div_done;

  lgu_datapath u_val (
    .clk, .loss_kind, .req, .cmd, .val, .mode, .last, .need_ln, .ln_done, .is_avg);

  lgu_acc #(.MAX_BATCH(MAX_BATCH)) u_batch (
    .clk, .rst_n, .cmd, .val, .mode, .last, .is_avg, .div_done, .res);

  assign sts = '{need_ln: need_ln, ln_done: ln_done, is_avg: is_avg, div_done: div_done};
endmodule
`default_nettype wire

@@ sv/loss_and_gradient_unit.sv @@
// Loss and gradient unit top level: controller plus datapath.
// Depends on lgu_pkg, lgu_ctrl, lgu_dp_fold (lgu_datapath, lgu_acc).
//
//  channel | direction | handshake           | payload
//  in_     | in        | in_valid/in_stall   | lgu_in_t
//  out_    | out       | out_valid/out_stall | lgu_out_t
//  cfg_    | in        | cfg_we              | cfg_data (loss_kind)
//
// One request at a time. Cross-entropy with ln adds 30 squarings of the squarer;
// the last element of a loss batch adds the fold and the bit-serial 64-bit divide.
// rst_n is synchronous; it clears the batch sum, count and loss_kind.
// A stalled result stays in the output register; the next request is accepted but waits for it to emit.
`default_nettype none
module loss_and_gradient_unit import lgu_pkg::*; #(
  parameter int unsigned MAX_BATCH_ELEMENTS = MAX_BATCH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire lgu_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output lgu_out_t     out_data,
  input  wire logic    cfg_we,
  input  wire logic    cfg_data
);
  logic     kind_r;
  lgu_cmd_t cmd;
  lgu_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= 1'b0;
    else if (cfg_we) kind_r <= cfg_data;
  end

  lgu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd);

  lgu_dp_fold #(.MAX_BATCH(MAX_BATCH_ELEMENTS)) u_dp (
    .clk, .rst_n, .loss_kind(kind_r), .req(in_data), .cmd,
    .sts, .res(out_data));
endmodule
`default_nettype wire
